// File: sv/hvn_pkg.sv
// Shared constants of the heightmap vertex normal unit.
package hvn_pkg;

  // Grid store geometry
  localparam int unsigned MaxCols = 256;
  localparam int unsigned MaxRows = 256;
  localparam int unsigned ColW    = $clog2(MaxCols);
  localparam int unsigned RowW    = $clog2(MaxRows);
  localparam int unsigned AddrW   = RowW + ColW;
  localparam int unsigned Depth   = MaxRows * MaxCols;

  // Configuration register indexes
  localparam logic CfgGridWidth  = 1'b0;
  localparam logic CfgGridHeight = 1'b1;

  // Fixed-point constants
  localparam int unsigned HeightScale = 1000;
  localparam logic signed [15:0] NormMax = 16'sd32767;

endpackage

// File: sv/heightmap_vertex_normal_unit.sv
// Heightmap store with vertex position and smoothed normal generation.
//
// The block holds a 256 x 256 grid of 8-bit heights in one on-chip memory
// (one write port, one registered read port). A write beat, or any beat
// outside the configured grid, goes from idle to the finish state, which
// loads the output register and returns to idle. A query beat reads the
// seven neighbour heights one per memory cycle, forms the normal sum from
// the adjacent triangles, drives one shared 21 x 21 multiplier for the x, z
// and y components and the three squares, runs one bit-serial square-root
// loop and uses one restoring divider, with a load step before each run,
// five times for the two grid coordinates and the three normal components.
// The height is scaled by a constant reciprocal multiply alongside. The next
// beat can be taken once the result is in the output register. One item is
// worked on at a time and the input is stalled until its result has been
// handed to the output register; a result held by a stalled output adds the
// stall cycles. The store has no reset; a sample that has never been written
// reads back as an unknown height.
module heightmap_vertex_normal_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [8:0]  cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_opcode_i,
  input  logic [7:0]  in_row_i,
  input  logic [7:0]  in_col_i,
  input  logic [7:0]  in_height_sample_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] out_vertex_index_o,
  output logic signed [16:0] out_pos_x_o,
  output logic [14:0] out_pos_y_o,
  output logic signed [16:0] out_pos_z_o,
  output logic signed [15:0] out_norm_x_o,
  output logic signed [15:0] out_norm_y_o,
  output logic signed [15:0] out_norm_z_o,
  output logic        out_range_error_o
);
  import hvn_pkg::*;

  // sequencer states
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRead  = 3'd1;
  localparam logic [2:0] StSum   = 3'd2;
  localparam logic [2:0] StMul   = 3'd3;
  localparam logic [2:0] StSqrt  = 3'd4;
  localparam logic [2:0] StDLoad = 3'd5;
  localparam logic [2:0] StDStep = 3'd6;
  localparam logic [2:0] StFin   = 3'd7;

  // neighbour slots in read order
  localparam logic [2:0] NbC  = 3'd0;
  localparam logic [2:0] NbD  = 3'd1;
  localparam logic [2:0] NbDR = 3'd2;
  localparam logic [2:0] NbR  = 3'd3;
  localparam logic [2:0] NbU  = 3'd4;
  localparam logic [2:0] NbL  = 3'd5;
  localparam logic [2:0] NbUL = 3'd6;
  localparam logic [2:0] NbLast = NbUL;

  // divider jobs
  localparam logic [2:0] DvPosX  = 3'd0;
  localparam logic [2:0] DvPosZ  = 3'd1;
  localparam logic [2:0] DvNormX = 3'd2;
  localparam logic [2:0] DvNormY = 3'd3;
  localparam logic [2:0] DvNormZ = 3'd4;

  localparam logic [4:0] DivLastStep = 5'd16;
  localparam logic [51:0] SqrtTopBit = 52'd1 << 50;

  // height to Q0.16: floor((h*8192 + 62) / 125) as a multiply by ceil(2^28 / 125)
  localparam logic [29:0] PosYRecip = 30'd2147484;
  localparam logic [43:0] PosYBias  = 44'd133144008;  // 62 times the reciprocal

  // configuration registers
  logic [8:0] grid_width_q, grid_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= 9'd256;
      grid_height_q <= 9'd256;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgGridWidth) grid_width_q <= cfg_data_i;
      else                           grid_height_q <= cfg_data_i;
    end
  end

  // effective grid size, clamped to 2..max
  logic [8:0] w_eff, h_eff;
  logic [7:0] wm1, hm1;

  always_comb begin
    if (grid_width_q < 9'd2)                 w_eff = 9'd2;
    else if (grid_width_q > 9'(MaxCols))     w_eff = 9'(MaxCols);
    else                                     w_eff = grid_width_q;
    if (grid_height_q < 9'd2)                h_eff = 9'd2;
    else if (grid_height_q > 9'(MaxRows))    h_eff = 9'(MaxRows);
    else                                     h_eff = grid_height_q;
  end
  assign wm1 = 8'(w_eff - 9'd1);
  assign hm1 = 8'(h_eff - 9'd1);

  // control and item registers
  logic [2:0]  state_q, state_d;
  logic        op_q, err_q;
  logic [7:0]  row_q, col_q;
  logic [2:0]  cnt_q;          // read slot or multiply step or divider job
  logic [4:0]  dcnt_q;
  logic        out_valid_q;

  logic accept;
  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;

  logic in_err;
  assign in_err = ({1'b0, in_row_i} >= h_eff) || ({1'b0, in_col_i} >= w_eff);

  // height memory
  logic [7:0] hmem [Depth];
  logic [7:0] rd_data_q;
  logic [AddrW-1:0] rd_addr;
  logic [7:0] rn, cn;

  always_comb begin
    rn = row_q;
    cn = col_q;
    unique case (cnt_q)
      NbD:  rn = row_q + 8'd1;
      NbDR: begin rn = row_q + 8'd1; cn = col_q + 8'd1; end
      NbR:  cn = col_q + 8'd1;
      NbU:  rn = row_q - 8'd1;
      NbL:  cn = col_q - 8'd1;
      NbUL: begin rn = row_q - 8'd1; cn = col_q - 8'd1; end
      default: ;
    endcase
  end
  assign rd_addr = {rn, cn};

  always_ff @(posedge clk_i) begin
    if (accept && !in_opcode_i && !in_err) begin
      hmem[{in_row_i, in_col_i}] <= in_height_sample_i;
    end
    rd_data_q <= hmem[rd_addr];
  end

  // neighbour heights
  logic [7:0] hgt_q [7];

  always_ff @(posedge clk_i) begin
    if (state_q == StRead && cnt_q != 3'd0) hgt_q[cnt_q - 3'd1] <= rd_data_q;
  end

  // triangle sums in raw height units
  logic t_dr, t_ur, t_dl, t_ul;
  logic signed [11:0] h0, hd, hdr, hr, hu, hl, hul;
  logic signed [11:0] xr, zr;
  logic [2:0] tri_cnt;

  assign h0  = $signed({4'b0, hgt_q[NbC]});
  assign hd  = $signed({4'b0, hgt_q[NbD]});
  assign hdr = $signed({4'b0, hgt_q[NbDR]});
  assign hr  = $signed({4'b0, hgt_q[NbR]});
  assign hu  = $signed({4'b0, hgt_q[NbU]});
  assign hl  = $signed({4'b0, hgt_q[NbL]});
  assign hul = $signed({4'b0, hgt_q[NbUL]});

  assign t_dr = ({1'b0, row_q} < hm1) && (col_q < wm1);
  assign t_ur = (row_q != 8'd0)       && (col_q < wm1);
  assign t_dl = ({1'b0, row_q} < hm1) && (col_q != 8'd0);
  assign t_ul = (row_q != 8'd0)       && (col_q != 8'd0);

  always_comb begin
    xr = '0;
    zr = '0;
    if (t_dr) begin
      xr = xr + (hd - hdr) + (h0 - hr);
      zr = zr + (h0 - hd) + (hr - hdr);
    end
    if (t_ur) begin
      xr = xr + (h0 - hr);
      zr = zr + (hu - h0);
    end
    if (t_dl) begin
      xr = xr + (hl - h0);
      zr = zr + (h0 - hd);
    end
    if (t_ul) begin
      xr = xr + (hl - h0) + (hul - hu);
      zr = zr + (hul - hl) + (hu - h0);
    end
  end
  assign tri_cnt = 3'({t_dr, 1'b0}) + 3'(t_ur) + 3'(t_dl) + 3'({t_ul, 1'b0});

  logic signed [11:0] xr_q, zr_q;
  logic [2:0] tcnt_q;

  // shared multiplier
  logic signed [20:0] mul_a, mul_b, nx_q, ny_q, nz_q;
  logic signed [41:0] prod;
  logic [39:0] s_q;

  always_comb begin
    mul_a = 21'(xr_q);
    mul_b = $signed({13'b0, wm1});
    unique case (cnt_q)
      3'd0: begin mul_a = 21'(xr_q); mul_b = $signed({13'b0, wm1}); end
      3'd1: begin mul_a = 21'(zr_q); mul_b = $signed({13'b0, hm1}); end
      3'd2: begin
        mul_a = $signed({18'b0, tcnt_q});
        mul_b = 21'(HeightScale);
      end
      3'd3: begin mul_a = nx_q; mul_b = nx_q; end
      3'd4: begin mul_a = ny_q; mul_b = ny_q; end
      3'd5: begin mul_a = nz_q; mul_b = nz_q; end
      default: ;
    endcase
  end
  assign prod = mul_a * mul_b;

  // square-root loop
  logic [51:0] v_q, res_q, bit_q, trial;
  logic [25:0] len_q;
  assign trial = res_q + bit_q;

  // divider operands
  logic signed [20:0] comp;
  logic [19:0] mag;
  logic [41:0] num;
  logic [26:0] dvs;

  always_comb begin
    unique case (cnt_q)
      DvNormY: comp = ny_q;
      DvNormZ: comp = nz_q;
      default: comp = nx_q;
    endcase
  end
  assign mag = comp[20] ? 20'(-comp) : 20'(comp);

  always_comb begin
    num = {mag, 22'b0} + 42'(len_q);
    dvs = {len_q, 1'b0};
    unique case (cnt_q)
      DvPosX: begin num = 42'({col_q, 17'b0}) + 42'(wm1); dvs = 27'({wm1, 1'b0}); end
      DvPosZ: begin num = 42'({row_q, 17'b0}) + 42'(hm1); dvs = 27'({hm1, 1'b0}); end
      default: ;
    endcase
  end

  // restoring divider, one quotient bit per cycle
  logic [26:0] rem_q, dvs_q;
  logic [16:0] nlo_q, quo_q, quo_n;
  logic [27:0] dtry;
  logic [26:0] rem_n;

  assign dtry = {rem_q, nlo_q[16]};
  always_comb begin
    if (dtry >= {1'b0, dvs_q}) begin
      rem_n = 27'(dtry - {1'b0, dvs_q});
      quo_n = {quo_q[15:0], 1'b1};
    end else begin
      rem_n = dtry[26:0];
      quo_n = {quo_q[15:0], 1'b0};
    end
  end

  logic signed [15:0] sat, nrm;
  assign sat = (quo_n > 17'd32767) ? NormMax : $signed(quo_n[15:0]);
  assign nrm = comp[20] ? -sat : sat;

  // height scaled by reciprocal multiplication
  logic [29:0] py_mul;
  logic [43:0] py_full;
  assign py_mul  = 30'(hgt_q[NbC]) * PosYRecip;
  assign py_full = {1'b0, py_mul, 13'b0} + PosYBias;

  // results held for the output register
  logic signed [16:0] px_q, pz_q;
  logic [14:0] py_q;
  logic signed [15:0] rx_q, ry_q, rz_q;

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (accept) state_d = (in_opcode_i && !in_err) ? StRead : StFin;
      StRead:  if (cnt_q == NbLast + 3'd1) state_d = StSum;
      StSum:   state_d = StMul;
      StMul:   if (cnt_q == 3'd5) state_d = StSqrt;
      StSqrt:  if (bit_q == 52'd1) state_d = StDLoad;
      StDLoad: state_d = StDStep;
      StDStep: if (dcnt_q == DivLastStep) state_d = (cnt_q == DvNormZ) ? StFin : StDLoad;
      StFin:   if (!out_valid_q || !out_stall_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        StIdle:  cnt_q <= '0;
        StRead:  cnt_q <= (state_d == StSum) ? 3'd0 : cnt_q + 3'd1;
        StMul:   cnt_q <= (state_d == StSqrt) ? 3'd0 : cnt_q + 3'd1;
        StDLoad: dcnt_q <= '0;
        StDStep: begin
          dcnt_q <= dcnt_q + 5'd1;
          if (dcnt_q == DivLastStep) cnt_q <= cnt_q + 3'd1;
        end
        default: ;
      endcase
      if (state_q == StFin && state_d == StIdle) out_valid_q <= 1'b1;
      else if (!out_stall_i)                      out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= in_opcode_i;
      row_q <= in_row_i;
      col_q <= in_col_i;
      err_q <= in_err;
    end
    if (state_q == StSum) begin
      xr_q   <= xr;
      zr_q   <= zr;
      tcnt_q <= tri_cnt;
      py_q   <= py_full[42:28];
    end
    if (state_q == StMul) begin
      unique case (cnt_q)
        3'd0: nx_q <= prod[20:0];
        3'd1: nz_q <= prod[20:0];
        3'd2: ny_q <= prod[20:0];
        3'd3: s_q  <= prod[39:0];
        default: s_q <= s_q + prod[39:0];
      endcase
      if (cnt_q == 3'd5) begin
        v_q   <= {s_q + prod[39:0], 12'b0};
        res_q <= '0;
        bit_q <= SqrtTopBit;
      end
    end
    if (state_q == StSqrt) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
      if (bit_q == 52'd1) begin
        if (v_q >= trial) len_q <= 26'((res_q >> 1) + bit_q);
        else              len_q <= (res_q[26:1] == 26'd0) ? 26'd1 : res_q[26:1];
      end
    end
    if (state_q == StDLoad) begin
      rem_q <= 27'(num[41:17]);
      nlo_q <= num[16:0];
      dvs_q <= dvs;
      quo_q <= '0;
    end
    if (state_q == StDStep) begin
      rem_q <= rem_n;
      nlo_q <= {nlo_q[15:0], 1'b0};
      quo_q <= quo_n;
      if (dcnt_q == DivLastStep) begin
        unique case (cnt_q)
          DvPosX:  px_q <= $signed(quo_n - 17'd32768);
          DvPosZ:  pz_q <= $signed(quo_n - 17'd32768);
          DvNormX: rx_q <= nrm;
          DvNormY: ry_q <= nrm;
          default: rz_q <= nrm;
        endcase
      end
    end
  end

  // output register
  logic [16:0] vidx;
  assign vidx = 17'(row_q) * 17'(w_eff) + 17'(col_q);

  always_ff @(posedge clk_i) begin
    if (state_q == StFin && state_d == StIdle) begin
      out_vertex_index_o <= err_q ? 16'd0 : vidx[15:0];
      out_range_error_o  <= err_q;
      if (err_q || !op_q) begin
        out_pos_x_o  <= '0;
        out_pos_y_o  <= '0;
        out_pos_z_o  <= '0;
        out_norm_x_o <= '0;
        out_norm_y_o <= '0;
        out_norm_z_o <= '0;
      end else begin
        out_pos_x_o  <= px_q;
        out_pos_y_o  <= py_q;
        out_pos_z_o  <= pz_q;
        out_norm_x_o <= rx_q;
        out_norm_y_o <= ry_q;
        out_norm_z_o <= rz_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
